@@ rtl/hfc_pkg.sv @@
// ----------------------------------------------------------------------------
// Hex float converter package
// Request codes and field constants shared by the converter modules.
// ----------------------------------------------------------------------------
`default_nettype none

package hfc_pkg;

  // Request codes carried with each transaction.
  typedef enum logic [1:0] {
    REQ_DEC32 = 2'd0,
    REQ_DEC64 = 2'd1,
    REQ_ENC32 = 2'd2,
    REQ_ENC64 = 2'd3
  } req_e;

  localparam int unsigned WordW = 64;
  localparam logic [6:0] HexExpMax = 7'h7F;

endpackage : hfc_pkg

`default_nettype wire

@@ rtl/hfc_core.sv @@
// ----------------------------------------------------------------------------
// Hex float converter core
// Combinational conversion of one word between hex float and double formats.
// ----------------------------------------------------------------------------
`default_nettype none

module hfc_core
  import hfc_pkg::*;
(
  input  var req_e             req_i,
  input  wire logic [63:0]     x_i,
  output logic      [63:0]     r_o
);

  // Decode path signals.
  logic        d_sign;
  logic [6:0]  d_exp;
  logic [55:0] d_frac;
  logic [5:0]  d_lz;
  logic [55:0] d_norm;
  logic [52:0] d_q;
  logic        d_rnd;
  logic [53:0] d_qr;
  logic [11:0] d_bexp;
  logic [63:0] d_res;

  // Encode path signals.
  logic        e_sign;
  logic [10:0] e_be;
  logic [51:0] e_f;
  logic [52:0] e_mant;
  logic [5:0]  e_lz;
  logic [52:0] e_norm;
  logic signed [12:0] e_b;
  logic signed [12:0] e_h;
  logic [1:0]  e_r;
  logic [55:0] e_m56;
  logic [25:0] e_m24w;
  logic [23:0] e_m24;
  logic signed [12:0] e_eb;
  logic [6:0]  e_ebc;
  logic        e_w24;
  logic [63:0] e_res;

  // Decode: normalize the fraction so its top bit sits at bit 55, then round.
  always_comb begin
    d_sign = (req_i == REQ_DEC32) ? x_i[31] : x_i[63];
    d_exp  = (req_i == REQ_DEC32) ? x_i[30:24] : x_i[62:56];
    d_frac = (req_i == REQ_DEC32) ? {x_i[23:0], 32'd0} : x_i[55:0];
    d_lz = 6'd0;
    for (int i = 0; i < 56; i++) begin
      if (d_frac[i]) d_lz = 6'(55 - i);
    end
    d_norm = d_frac << d_lz;
    d_q    = d_norm[55:3];
    d_rnd  = d_norm[2] && (d_norm[1] || d_norm[0] || d_norm[3]);
    d_qr   = {1'b0, d_q} + 54'(d_rnd);
    // value = frac/2^56 * 16^(e-64): unbiased exponent is 4e-256-1-lz.
    d_bexp = 12'({5'd0, d_exp} << 2) + 12'd766 - 12'(d_lz) + 12'(d_qr[53]);
    if (d_frac == 56'd0) d_res = 64'd0;
    else d_res = {d_sign, d_bexp[10:0], d_qr[53] ? d_qr[52:1] : d_qr[51:0]};
  end

  // Encode: normalize the significand, align to a hex digit boundary.
  always_comb begin
    e_w24  = (req_i == REQ_ENC32);
    e_sign = x_i[63];
    e_be   = x_i[62:52];
    e_f    = x_i[51:0];
    e_mant = (e_be == 11'd0) ? {1'b0, e_f} : {1'b1, e_f};
    e_lz = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (e_mant[i]) e_lz = 6'(52 - i);
    end
    e_norm = e_mant << e_lz;
    // Binary exponent of the leading one, b = be - 1023 - lz (subnormal: -1022 - lz).
    e_b = $signed({2'b0, (e_be == 11'd0) ? 11'd1 : e_be}) - 13'sd1023
          - $signed({7'd0, e_lz});
    e_h = (e_b + 13'sd1100) >>> 2;
    e_h = e_h - 13'sd274;
    // Shift right so leading one lands (3 - r) below the digit top.
    e_r = 2'(e_b + 13'sd1100);
    e_m56  = {e_norm, 3'd0} >> (2'd3 - e_r);
    e_m24w = {1'b0, e_m56[55:31]} + 26'd1;
    e_m24  = e_m24w[25] ? 24'hFF_FFFF : e_m24w[24:1];
    e_eb   = e_h + 13'sd64;
    if (e_eb < 0) e_ebc = 7'd0;
    else if (e_eb > 13'sd127) e_ebc = HexExpMax;
    else e_ebc = e_eb[6:0];
    if (e_be == 11'd0 && e_f == 52'd0) e_res = 64'd0;
    else if (e_be == 11'h7FF)
      e_res = e_w24 ? {32'd0, e_sign, HexExpMax, 24'hFF_FFFF}
                    : {e_sign, HexExpMax, 56'hFF_FFFF_FFFF_FFFF};
    else
      e_res = e_w24 ? {32'd0, e_sign, e_ebc, e_m24} : {e_sign, e_ebc, e_m56};
  end

  assign r_o = (req_i == REQ_DEC32 || req_i == REQ_DEC64) ? d_res : e_res;

endmodule : hfc_core

`default_nettype wire

@@ rtl/hex_float_ieee_double_converter.sv @@
// ----------------------------------------------------------------------------
// Hex float / IEEE double converter
// Two-register pipeline around a single-pass conversion core.
// ----------------------------------------------------------------------------
// One 64-bit word enters per clock and its result leaves through an input
// register and then a result register; the conversion core between them
// sets the clock period. Both registers advance whenever the result
// register is empty or being taken, so throughput is one transaction per
// cycle without output stall.
`default_nettype none

module hex_float_ieee_double_converter
  import hfc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [63:0] operand_bits_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [63:0]      result_bits_o
);

  logic        in_v_q;
  req_e        req_q;
  logic [63:0] x_q;
  logic        out_v_q;
  logic [63:0] res_q;
  logic [63:0] res_d;
  logic        adv_out;
  logic        adv_in;

  // Pipeline advances when the next stage can take data.
  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv_in     = !in_v_q || adv_out;
  assign in_stall_o = !adv_in;

  hfc_core u_core (
    .req_i (req_q),
    .x_i   (x_q),
    .r_o   (res_d)
  );

  // Input and result registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_in) in_v_q <= in_valid_i;
      if (adv_out) out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_in && in_valid_i) begin
      req_q <= req_e'(req_type_i);
      x_q   <= operand_bits_i;
    end
    if (adv_out && in_v_q) res_q <= res_d;
  end

  assign out_valid_o   = out_v_q;
  assign result_bits_o = res_q;

  // A stalled result holds until taken.
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_stall_i |=> out_v_q && $stable(res_q))
    else $error("result changed while stalled");

  // Input stall only when both stages are full and the output is blocked.
  a_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_v_q && out_v_q && out_stall_i)
    else $error("spurious input stall");

  // An accepted transaction occupies the input stage next cycle.
  a_fill : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_v_q)
    else $error("accepted transaction lost");

endmodule : hex_float_ieee_double_converter

`default_nettype wire
